// File: sv/brq_pkg.sv
// Shared types, constants and helper functions for the BF16 row quantizer.
// Used by brq_ctrl, brq_datapath and bf16_row_int8_quantizer; no dependencies.
package brq_pkg;

    // IEEE single constants
    localparam logic [31:0] FP32_ONE = 32'h3F80_0000;
    localparam logic [31:0] FP32_INF = 32'h7F80_0000;
    localparam int unsigned FP32_BIAS = 127;

    // 127.0 as a normalized 8-bit mantissa 1.1111110 with exponent 6
    localparam logic [7:0] MANT_127 = 8'hFE;
    localparam int unsigned EXP_127 = 6;

    // Largest BF16 magnitude that is not a NaN (infinity)
    localparam logic [14:0] BF16_INF_MAG = 15'h7F80;

    // Quotient bits produced by the divider: leading one, 23 fraction, guard, extra
    localparam int unsigned DIV_BITS = 26;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS + 1);

    // Saturation magnitude of the int8 result
    localparam logic [6:0] QMAX = 7'd127;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;          // request taken on the input channel
        logic mul_load;        // register the quantize product
        logic load_quant;      // move the quantized word into the output register
        logic div_load_scale;  // load the amax / 127 quotient
        logic div_load_inv;    // start 127 / amax
        logic div_step;        // advance the divider one bit
        logic scale_store;     // hold the rounded row scale
        logic inv_store;       // latch the factor and clear the running max
        logic load_scale;      // move the row scale into the output register
    } brq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_busy;
    } brq_sts_t;

    // Normalized BF16 magnitude: 1.xxxxxxx mantissa and unbiased exponent
    typedef struct packed {
        logic [7:0]         ma;
        logic signed [10:0] ea;
    } brq_norm_t;

    // Normalize a BF16 exponent and mantissa; subnormals are shifted up.
    function automatic brq_norm_t bf16_norm(input logic [7:0] e, input logic [6:0] m);
        brq_norm_t          r;
        logic [6:0]         mm;
        logic signed [10:0] ex;
        mm = m;
        ex = -11'sd127;
        if (e != 8'd0) begin
            r.ma = {1'b1, m};
            r.ea = signed'({3'b000, e}) - 11'sd127;
        end else begin
            for (int i = 0; i < 7; i++) begin
                if (!mm[6]) begin
                    mm = {mm[5:0], 1'b0};
                    ex = ex - 11'sd1;
                end
            end
            r.ma = {mm, 1'b0};
            r.ea = ex;
        end
        return r;
    endfunction

endpackage

// File: sv/bf16_row_int8_quantizer.sv
// Top level of the BF16 row quantizer: controller plus datapath.
// Depends on brq_pkg, brq_ctrl and brq_datapath.
//
// Each row is streamed twice. Scan words (mode 0) update a running maximum and give
// no result; for the scan word with row_end, amax/127 is formed by a constant
// multiplication, then 127/amax runs through a bit-serial divider of 26 steps, and
// the row scale goes through states SLOAD, SFIN, ILOAD, IDIV, IFIN and SOUT before
// it is loaded into the output register. Quantize words (mode 1) go through a
// registered 8x24 mantissa multiplier and a rounding stage into the output register,
// once that is free, and then the next request can be taken. The block works on
// one request at a time; the output register lets a finished result wait for
// m_ready while the next request is taken, and a further result waits inside the
// block until that register drains.
module bf16_row_int8_quantizer import brq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [15:0]       s_value_bits,
    input  logic              s_row_end,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_scale,
    output logic signed [7:0] m_quant_value,
    output logic [31:0]       m_scale_bits,
    output logic              m_last
);

    brq_cmd_t cmd;
    brq_sts_t sts;

    // Sequencer
    brq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_row_end (s_row_end),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Arithmetic and payload
    brq_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_mode        (s_mode),
        .s_value_bits  (s_value_bits),
        .s_row_end     (s_row_end),
        .m_is_scale    (m_is_scale),
        .m_quant_value (m_quant_value),
        .m_scale_bits  (m_scale_bits),
        .m_last        (m_last)
    );

endmodule

// File: sv/brq_ctrl.sv
// Controller state machine of the BF16 row quantizer.
// Depends on brq_pkg for the command and status structs.
module brq_ctrl import brq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_mode,
    input  logic     s_row_end,
    output logic     m_valid,
    input  logic     m_ready,
    output brq_cmd_t cmd,
    input  brq_sts_t sts
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_QMUL  = 4'd1;
    localparam logic [3:0] ST_QOUT  = 4'd2;
    localparam logic [3:0] ST_SLOAD = 4'd3;
    localparam logic [3:0] ST_SFIN  = 4'd5;
    localparam logic [3:0] ST_ILOAD = 4'd6;
    localparam logic [3:0] ST_IDIV  = 4'd7;
    localparam logic [3:0] ST_IFIN  = 4'd8;
    localparam logic [3:0] ST_SOUT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // The output register can take a result when it is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_mode) begin
                        state_next = ST_QMUL;
                    end else if (s_row_end) begin
                        state_next = ST_SLOAD;
                    end
                end
            end
            ST_QMUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_QOUT;
            end
            ST_QOUT: begin
                if (out_free) begin
                    cmd.load_quant = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SLOAD: begin
                cmd.div_load_scale = 1'b1;
                state_next         = ST_SFIN;
            end
            ST_SFIN: begin
                cmd.scale_store = 1'b1;
                state_next      = ST_ILOAD;
            end
            ST_ILOAD: begin
                cmd.div_load_inv = 1'b1;
                state_next       = ST_IDIV;
            end
            ST_IDIV: begin
                cmd.div_step = 1'b1;
                if (!sts.div_busy) begin
                    state_next = ST_IFIN;
                end
            end
            ST_IFIN: begin
                cmd.inv_store = 1'b1;
                state_next    = ST_SOUT;
            end
            ST_SOUT: begin
                if (out_free) begin
                    cmd.load_scale = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_quant || cmd.load_scale) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A result is loaded only when the output register is free.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_quant || cmd.load_scale) |-> out_free)
        else $error("result loaded over a pending output");

    // At most one result source per cycle.
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_quant, cmd.load_scale}))
        else $error("two result loads in one cycle");

    // A new request is taken only while no item is in flight.
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> (state_reg == ST_IDLE && !sts.div_busy))
        else $error("request accepted while busy");

endmodule

// File: sv/brq_datapath.sv
// Datapath of the BF16 row quantizer: running max, bit-serial divider,
// FP32 rounding, quantize multiplier and the output payload register.
// Depends on brq_pkg.
module brq_datapath import brq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  brq_cmd_t          cmd,
    output brq_sts_t          sts,
    input  logic              s_mode,
    input  logic [15:0]       s_value_bits,
    input  logic              s_row_end,
    output logic              m_is_scale,
    output logic signed [7:0] m_quant_value,
    output logic [31:0]       m_scale_bits,
    output logic              m_last
);

    // Round a positive quotient 1.q * 2^(be-127) to IEEE single, with subnormals.
    function automatic logic [31:0] fp32_pack(input logic [DIV_BITS-1:0] q,
                                              input logic st,
                                              input logic signed [10:0] be);
        logic [DIV_BITS:0]  sig;
        logic [DIV_BITS:0]  sh_sig;
        logic [DIV_BITS:0]  mask;
        logic signed [10:0] shs;
        logic [4:0]         sh;
        logic               lost;
        logic [23:0]        mant;
        logic               g;
        logic               stk;
        logic [24:0]        r;
        logic [10:0]        e;
        logic [31:0]        res;
        sig = {q, st};
        shs = 11'sd1 - be;
        if (be > 11'sd0) begin
            sh = 5'd0;
        end else if (shs > 11'sd26) begin
            sh = 5'd27;
        end else begin
            sh = shs[4:0];
        end
        mask   = ~({(DIV_BITS + 1){1'b1}} << sh);
        lost   = |(sig & mask);
        sh_sig = sig >> sh;
        mant   = sh_sig[DIV_BITS:3];
        g      = sh_sig[2];
        stk    = (|sh_sig[1:0]) | lost;
        r      = {1'b0, mant} + {24'd0, g & (stk | mant[0])};
        if (be > 11'sd0) begin
            e = be + {10'd0, r[24]};
            if (signed'(e) >= 11'sd255) begin
                res = FP32_INF;
            end else begin
                res = {1'b0, e[7:0], (r[24] ? 23'd0 : r[22:0])};
            end
        end else begin
            res = {1'b0, 7'd0, r[23], r[22:0]};
        end
        return res;
    endfunction

    logic [15:0]             in_word_reg;
    logic                    in_end_reg;
    logic [14:0]             max_reg, max_next;
    logic [31:0]             inv_reg, inv_next;
    logic [31:0]             scale_hold_reg;

    logic [9:0]              div_rem_reg;
    logic [7:0]              div_den_reg;
    logic [DIV_BITS-1:0]     div_quo_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic signed [10:0]      div_be_reg;

    logic [31:0]             prod_reg;
    logic signed [10:0]      pexp_reg;
    logic                    psign_reg;
    logic                    pzero_reg;
    logic                    psat_reg;

    // Running maximum of the scan pass; a NaN never wins
    logic [14:0] in_mag;
    assign in_mag = s_value_bits[14:0];

    always_comb begin
        max_next = max_reg;
        if (cmd.accept && !s_mode && in_mag > max_reg && !(in_mag > BF16_INF_MAG)) begin
            max_next = in_mag;
        end
        if (cmd.inv_store) begin
            max_next = '0;
        end
    end

    // Divider operand setup for 127 / amax
    brq_norm_t          amax_n;
    logic               amax_zero;
    logic               amax_inf;
    logic [7:0]         d_num;
    logic [7:0]         d_den;
    logic signed [10:0] d_ebase;
    logic               d_shift;

    assign amax_n    = bf16_norm(max_reg[14:7], max_reg[6:0]);
    assign amax_zero = (max_reg == 15'd0);
    assign amax_inf  = (max_reg[14:7] == 8'hFF);

    always_comb begin
        d_num   = MANT_127;
        d_den   = amax_n.ma;
        d_ebase = 11'(EXP_127) - amax_n.ea;
        d_shift = (d_num < d_den);
    end

    // amax / 127 by constant multiplication: 2^28 - 1 is a multiple of 127, so
    // floor(ma * 2^28 / 127) = ma * (1 + 2^7 + 2^14 + 2^21) + floor(ma / 127).
    // The remainder ma mod 127 is zero only for ma = 254.
    logic [29:0]        sq_full;
    logic               sq_big;
    logic [DIV_BITS-1:0] sq_quo;
    logic               sq_sticky;
    logic signed [10:0] sq_be;

    assign sq_big    = (amax_n.ma >= 8'd254);
    assign sq_full   = ({22'd0, amax_n.ma} << 21) + ({22'd0, amax_n.ma} << 14) +
                       ({22'd0, amax_n.ma} << 7) + {22'd0, amax_n.ma} +
                       (sq_big ? 30'd2 : 30'd1);
    assign sq_quo    = sq_big ? sq_full[29:4] : sq_full[28:3];
    assign sq_sticky = (amax_n.ma != 8'd254);
    assign sq_be     = amax_n.ea - 11'sd7 + (sq_big ? 11'sd1 : 11'sd0) + 11'(FP32_BIAS);

    // One restoring division step per cycle
    logic       d_bit;
    logic [9:0] d_rem_sub;

    assign d_bit     = (div_rem_reg >= {2'b00, div_den_reg});
    assign d_rem_sub = d_bit ? (div_rem_reg - {2'b00, div_den_reg}) : div_rem_reg;
    assign sts.div_busy = (div_cnt_reg != '0);

    always_comb begin
        div_cnt_next = div_cnt_reg;
        if (cmd.div_load_inv) begin
            div_cnt_next = DIV_CNT_W'(DIV_BITS);
        end else if (cmd.div_step && sts.div_busy) begin
            div_cnt_next = div_cnt_reg - 1'b1;
        end
    end

    // The scale quotient is loaded whole; the factor is divided bit by bit.
    always_ff @(posedge aclk) begin
        if (cmd.div_load_scale) begin
            div_rem_reg <= {9'd0, sq_sticky};
            div_quo_reg <= sq_quo;
            div_be_reg  <= sq_be;
        end else if (cmd.div_load_inv) begin
            div_rem_reg <= d_shift ? {1'b0, d_num, 1'b0} : {2'b00, d_num};
            div_den_reg <= d_den;
            div_quo_reg <= '0;
            div_be_reg  <= d_ebase - (d_shift ? 11'sd1 : 11'sd0) + 11'(FP32_BIAS);
        end else if (cmd.div_step && sts.div_busy) begin
            div_rem_reg <= {d_rem_sub[8:0], 1'b0};
            div_quo_reg <= {div_quo_reg[DIV_BITS-2:0], d_bit};
        end
    end

    // Rounded quotient and the special rows
    logic [31:0] div_fp;
    assign div_fp = fp32_pack(div_quo_reg, div_rem_reg != 10'd0, div_be_reg);

    always_comb begin
        inv_next = inv_reg;
        if (cmd.inv_store) begin
            inv_next = (amax_zero || amax_inf) ? 32'd0 : div_fp;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scale_store) begin
            if (amax_inf) begin
                scale_hold_reg <= FP32_INF;
            end else if (amax_zero || div_fp == 32'd0) begin
                scale_hold_reg <= FP32_ONE;
            end else begin
                scale_hold_reg <= div_fp;
            end
        end
    end

    // Quantize stage one: classify and multiply the mantissas
    brq_norm_t          v_n;
    logic [7:0]         v_e;
    logic [6:0]         v_m;
    logic               v_nan;
    logic               v_inf;
    logic               v_zero;
    logic               f_zero;
    logic               f_inf;
    logic signed [10:0] f_ea;

    assign v_e    = in_word_reg[14:7];
    assign v_m    = in_word_reg[6:0];
    assign v_n    = bf16_norm(v_e, v_m);
    assign v_nan  = (v_e == 8'hFF) && (v_m != 7'd0);
    assign v_inf  = (v_e == 8'hFF) && (v_m == 7'd0);
    assign v_zero = (v_e == 8'd0) && (v_m == 7'd0);
    assign f_zero = (inv_reg == 32'd0);
    assign f_inf  = (inv_reg == FP32_INF);
    assign f_ea   = signed'({3'b000, inv_reg[30:23]}) - 11'(FP32_BIAS);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_word_reg <= s_value_bits;
            in_end_reg  <= s_row_end;
        end
        if (cmd.mul_load) begin
            prod_reg  <= {24'd0, v_n.ma} * {8'd0, 1'b1, inv_reg[22:0]};
            pexp_reg  <= v_n.ea + f_ea;
            psign_reg <= in_word_reg[15];
            pzero_reg <= v_nan || f_zero || v_zero;
            psat_reg  <= v_inf || f_inf;
        end
    end

    // Quantize stage two: FP32 rounding of the product, then round half away
    logic signed [10:0] q_ep;
    logic signed [10:0] q_eps;
    logic [31:0]        q_pn;
    logic [23:0]        q_mant;
    logic [24:0]        q_r;
    logic [32:0]        q_x;
    logic [8:0]         q_mag9;
    logic [6:0]         q_mag;
    logic [7:0]         q_val;

    always_comb begin
        q_ep   = pexp_reg + (prod_reg[31] ? 11'sd1 : 11'sd0);
        q_eps  = q_ep + 11'sd2;
        q_pn   = prod_reg[31] ? prod_reg : {prod_reg[30:0], 1'b0};
        q_mant = q_pn[31:8];
        q_r    = {1'b0, q_mant} + {24'd0, q_pn[7] & ((|q_pn[6:0]) | q_mant[0])};
        q_x    = {8'd0, q_r} << q_eps[3:0];
        q_mag9 = {1'b0, q_x[32:25]} + {8'd0, q_x[24]};
        if (pzero_reg) begin
            q_mag = 7'd0;
        end else if (psat_reg || q_ep >= 11'sd7) begin
            q_mag = QMAX;
        end else if (q_ep < -11'sd2) begin
            q_mag = 7'd0;
        end else if (q_mag9 >= {2'b00, QMAX}) begin
            q_mag = QMAX;
        end else begin
            q_mag = q_mag9[6:0];
        end
        q_val = psign_reg ? (8'd0 - {1'b0, q_mag}) : {1'b0, q_mag};
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (cmd.load_quant) begin
            m_is_scale    <= 1'b0;
            m_quant_value <= signed'(q_val);
            m_scale_bits  <= 32'd0;
            m_last        <= in_end_reg;
        end else if (cmd.load_scale) begin
            m_is_scale    <= 1'b1;
            m_quant_value <= 8'sd0;
            m_scale_bits  <= scale_hold_reg;
            m_last        <= 1'b1;
        end
    end

    // Row state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg     <= '0;
            inv_reg     <= '0;
            div_cnt_reg <= '0;
        end else begin
            max_reg     <= max_next;
            inv_reg     <= inv_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // The running maximum never holds a NaN pattern.
    a_max_not_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        !(max_reg > BF16_INF_MAG))
        else $error("running maximum holds a NaN");

    // Starting the factor division always leaves the divider busy.
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load_inv |=> sts.div_busy)
        else $error("divider did not start");

    // The maximum is cleared once the factor is latched.
    a_max_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.inv_store |=> (max_reg == 15'd0))
        else $error("running maximum not cleared at row end");

endmodule
